// ===== rtl/core/video_frame_reassembler_unit_macros.svh =====
// assertion macros for the frame reassembler
`ifndef VIDEO_FRAME_REASSEMBLER_UNIT_MACROS_SVH
`define VIDEO_FRAME_REASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfr assertion failed");

// next-cycle implication, checked out of reset
`define VFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfr assertion failed");

`endif

// ===== rtl/core/vfr_pkg.sv =====
// shared types and constants for the frame reassembler
`default_nettype none

package vfr_pkg;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_HEADER  = 2'd1,
        OP_PAYLOAD = 2'd2,
        OP_READ    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_READY    = 2'd1,
        EV_OVERFLOW = 2'd2,
        EV_READ     = 2'd3
    } t_event;

    localparam logic [16:0] MIN_FRAME_LEN = 17'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  frame_tag;
        logic [7:0]  packet_seq;
        logic        end_of_frame;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic [16:0] capacity;
        logic [15:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [16:0] frame_length;
        logic [7:0]  read_data;
    } t_out_item;

    typedef struct packed {
        logic        en;
        logic [16:0] addr;
        logic [7:0]  data;
    } t_wr_req;

    typedef struct packed {
        t_event      ev;
        logic [16:0] frame_length;
        t_wr_req     wr;
    } t_ctrl_res;

endpackage

`default_nettype wire

// ===== rtl/core/vfr_store.sv =====
// frame byte store: one write and one read per cycle, registered read data
`default_nettype none

module vfr_store #(
    parameter int STORE_DEPTH = 65536
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  vfr_pkg::t_wr_req    i_wr,
    input  wire                 i_rd_en,
    input  wire  [15:0]         i_rd_addr,
    output logic [7:0]          o_rd_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [7:0]  mem [STORE_DEPTH];
    logic [31:0] wr_addr_w;
    logic [31:0] rd_addr_w;
    logic        wr_hit;
    logic        rd_hit;
    logic [7:0]  r_rd_data;
    logic        r_rd_hit;

    assign wr_addr_w = 32'(i_wr.addr);
    assign rd_addr_w = 32'(i_rd_addr);
    assign wr_hit    = i_wr.en && (wr_addr_w < 32'(STORE_DEPTH));
    assign rd_hit    = rd_addr_w < 32'(STORE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            mem[wr_addr_w[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en && rd_hit) begin
            r_rd_data <= mem[rd_addr_w[AW-1:0]];
        end
    end

    // addresses past the store read back as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_hit <= rd_hit;
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 8'h00;

endmodule

`default_nettype wire

// ===== rtl/core/vfr_ctrl.sv =====
// capture control: frame/packet tracking, byte placement and frame check
`default_nettype none

module vfr_ctrl #(
    parameter int STORE_DEPTH = 65536
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  vfr_pkg::t_in_item   i_item,
    output vfr_pkg::t_ctrl_res  o_res
);

    typedef enum logic [1:0] {
        FILL_DONE = 2'd0,
        FILL_COPY = 2'd1,
        FILL_FULL = 2'd2
    } t_fill;

    logic        r_armed,   n_armed;
    logic [16:0] r_usable,  n_usable;
    logic        r_tag_none, n_tag_none;
    logic [7:0]  r_tag,     n_tag;
    logic [8:0]  r_pkts,    n_pkts;
    logic [16:0] r_bytes,   n_bytes;
    t_fill       r_fill,    n_fill;
    logic [15:0] r_left,    n_left;
    logic        r_open,    n_open;
    logic        r_closes,  n_closes;
    logic [15:0] r_head,    n_head;
    logic [55:0] r_tail,    n_tail;

    logic [16:0] room;
    logic        new_frame;
    vfr_pkg::t_ctrl_res res;

    // soi at the start, eoi seven bytes from the end, little-endian length trailer
    function automatic logic frame_good(input logic [16:0] len, input logic [15:0] head,
                                        input logic [55:0] tail);
        logic [31:0] stated;
        stated = {tail[7:0], tail[15:8], tail[23:16], tail[31:24]};
        return (len >= vfr_pkg::MIN_FRAME_LEN) && (head == 16'hFFD8) &&
               (tail[55:48] == 8'hFF) && (tail[47:40] == 8'hD9) &&
               (stated == 32'(len) - 32'd5);
    endfunction

    assign new_frame = (r_tag_none || (i_item.frame_tag != r_tag)) &&
                       (i_item.packet_seq == 8'd1);

    always_comb begin
        n_armed    = r_armed;
        n_usable   = r_usable;
        n_tag_none = r_tag_none;
        n_tag      = r_tag;
        n_pkts     = r_pkts;
        n_bytes    = r_bytes;
        n_fill     = r_fill;
        n_left     = r_left;
        n_open     = r_open;
        n_closes   = r_closes;
        n_head     = r_head;
        n_tail     = r_tail;
        room       = '0;
        res        = '0;
        res.ev     = vfr_pkg::EV_NONE;

        unique case (vfr_pkg::t_opcode'(i_item.opcode))
            vfr_pkg::OP_ARM: begin
                if (!r_armed && (i_item.capacity != 17'd0)) begin
                    n_armed  = 1'b1;
                    n_usable = (32'(i_item.capacity) > 32'(STORE_DEPTH)) ?
                               17'(STORE_DEPTH) : i_item.capacity;
                end
            end
            vfr_pkg::OP_HEADER: begin
                if (r_armed) begin
                    n_open = 1'b0;
                    n_left = '0;
                    if (new_frame) begin
                        n_tag_none = 1'b0;
                        n_tag      = i_item.frame_tag;
                        n_bytes    = '0;
                        n_pkts     = '0;
                        n_fill     = FILL_COPY;
                        n_head     = '0;
                        n_tail     = '0;
                    end
                    if (!n_tag_none && (i_item.frame_tag == n_tag) &&
                        ({1'b0, n_pkts} + 10'd1 == {2'b00, i_item.packet_seq}) &&
                        (n_fill == FILL_COPY)) begin
                        room = (r_usable > n_bytes) ? r_usable - n_bytes : '0;
                        if ({1'b0, i_item.payload_length} <= room) begin
                            n_pkts   = n_pkts + 9'd1;
                            n_closes = i_item.end_of_frame;
                            n_left   = i_item.payload_length;
                            if (i_item.payload_length != 16'd0) begin
                                n_open = 1'b1;
                            end else if (i_item.end_of_frame &&
                                         frame_good(n_bytes, n_head, n_tail)) begin
                                n_fill           = FILL_DONE;
                                n_armed          = 1'b0;
                                n_open           = 1'b0;
                                res.ev           = vfr_pkg::EV_READY;
                                res.frame_length = n_bytes;
                            end
                        end else begin
                            n_fill = FILL_FULL;
                            res.ev = vfr_pkg::EV_OVERFLOW;
                        end
                    end
                end
            end
            vfr_pkg::OP_PAYLOAD: begin
                if (r_armed && r_open && (r_fill == FILL_COPY)) begin
                    res.wr.en   = i_fire;
                    res.wr.addr = r_bytes;
                    res.wr.data = i_item.payload_byte;
                    if (r_bytes == 17'd0) begin
                        n_head = {i_item.payload_byte, 8'h00};
                    end else if (r_bytes == 17'd1) begin
                        n_head = {r_head[15:8], i_item.payload_byte};
                    end
                    n_tail  = {r_tail[47:0], i_item.payload_byte};
                    n_bytes = r_bytes + 17'd1;
                    n_left  = r_left - 16'd1;
                    if (n_left == 16'd0) begin
                        n_open = 1'b0;
                        if (r_closes && frame_good(n_bytes, n_head, n_tail)) begin
                            n_fill           = FILL_DONE;
                            n_armed          = 1'b0;
                            res.ev           = vfr_pkg::EV_READY;
                            res.frame_length = n_bytes;
                        end
                    end
                end
            end
            vfr_pkg::OP_READ: begin
                res.ev = vfr_pkg::EV_READ;
            end
            default: begin
                res.ev = vfr_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_usable   <= '0;
            r_tag_none <= 1'b1;
            r_tag      <= '0;
            r_pkts     <= '0;
            r_bytes    <= '0;
            r_fill     <= FILL_DONE;
            r_left     <= '0;
            r_open     <= 1'b0;
            r_closes   <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
        end else if (i_fire) begin
            r_armed    <= n_armed;
            r_usable   <= n_usable;
            r_tag_none <= n_tag_none;
            r_tag      <= n_tag;
            r_pkts     <= n_pkts;
            r_bytes    <= n_bytes;
            r_fill     <= n_fill;
            r_left     <= n_left;
            r_open     <= n_open;
            r_closes   <= n_closes;
            r_head     <= n_head;
            r_tail     <= n_tail;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

// ===== rtl/core/video_frame_reassembler_unit.sv =====
// top level of the frame reassembler
// Rebuilds one JPEG frame from tagged packets into an on-chip byte store and
// reads it back by address. Every input transaction yields exactly one result
// transaction. A transaction is taken every clock cycle when the output side
// keeps up: it passes an input register, then the capture-state update with a
// single store access (write for payload bytes, read for read-back), and lands
// in the result register. The store has no reset or clearing pass; reading a
// location never written returns arbitrary data.
`default_nettype none
`include "video_frame_reassembler_unit_macros.svh"

module video_frame_reassembler_unit #(
    parameter int STORE_DEPTH = 65536
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  vfr_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output vfr_pkg::t_out_item  o_out_data,
    input  wire                 i_out_stall
);

    logic               r_in_valid;
    vfr_pkg::t_in_item  r_in;
    logic               r_out_valid;
    vfr_pkg::t_event    r_event;
    logic [16:0]        r_len;
    logic               out_ready;
    logic               fire;
    logic               rd_en;
    logic [7:0]         rd_data;
    vfr_pkg::t_ctrl_res ctrl_res;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign rd_en      = fire && (vfr_pkg::t_opcode'(r_in.opcode) == vfr_pkg::OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    vfr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (ctrl_res)
    );

    vfr_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ctrl_res.wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_in.read_address),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_event     <= vfr_pkg::EV_NONE;
            r_len       <= '0;
        end else if (out_ready) begin
            r_out_valid <= fire;
            if (fire) begin
                r_event <= ctrl_res.ev;
                r_len   <= ctrl_res.frame_length;
            end
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.event_res    = r_event;
    assign o_out_data.frame_length = r_len;
    assign o_out_data.read_data    = (r_event == vfr_pkg::EV_READ) ? rd_data : 8'h00;

    // a transaction held back by the output side is not dropped
    `VFR_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !out_ready, r_in_valid)
    // a ready frame is never shorter than the minimum frame length
    `VFR_ASSERT_NOW(a_ready_len, i_clk, i_rst_n, r_out_valid && (r_event == vfr_pkg::EV_READY), r_len >= vfr_pkg::MIN_FRAME_LEN)
    // length only accompanies a ready frame
    `VFR_ASSERT_NOW(a_len_zero, i_clk, i_rst_n, r_out_valid && (r_event != vfr_pkg::EV_READY), r_len == 17'd0)
    // a store write only happens on a payload byte going through
    `VFR_ASSERT_NOW(a_wr_payload, i_clk, i_rst_n, ctrl_res.wr.en, fire && (vfr_pkg::t_opcode'(r_in.opcode) == vfr_pkg::OP_PAYLOAD))

endmodule

`default_nettype wire

// ===== tb/sv/video_frame_reassembler_unit_test.sv =====
// self-checking testbench for the video frame reassembler unit
`timescale 1ns / 1ps

module video_frame_reassembler_unit_test;
    import vfr_pkg::*;

    localparam int STORE_DEPTH  = 65536;
    localparam int RANDOM_ITEMS = 1800;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_SETTLE  = 8;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [15:0] SOI_MARKER = 16'hFFD8;
    localparam logic [15:0] EOI_MARKER = 16'hFFD9;

    typedef enum logic [1:0] {
        FILL_DONE,
        FILL_COPY,
        FILL_FULL
    } t_fill_state;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_step_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    // reassembly state mirrored from the block
    bit          cap_armed     = 1'b0;
    logic [16:0] cap_usable    = '0;
    logic [15:0] cur_tag       = 16'hFFFF;
    logic [8:0]  pkts_done     = '0;
    logic [16:0] fill_count    = '0;
    t_fill_state fill_state    = FILL_DONE;
    logic [15:0] pkt_remaining = '0;
    bit          pkt_open      = 1'b0;
    bit          pkt_last      = 1'b0;
    logic [15:0] soi_bytes     = '0;
    logic [55:0] tail_bytes    = '0;
    bit   [7:0]  store_img [0:STORE_DEPTH-1];
    // frames always fill from address zero, so everything below this is written
    int          written_top   = 0;

    t_out_item pending_results [$];
    t_step_row directed_steps [$];

    int cycle_count     = 0;
    int burst_left      = 0;
    int items_sent      = 0;
    int effective_items = 0;
    int results_checked = 0;
    int frames_ready    = 0;
    int overflows_seen  = 0;
    int reads_seen      = 0;
    int fail_count      = 0;

    video_frame_reassembler_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("FAIL video_frame_reassembler_unit");
        $finish;
    end

    // completion check of the frame gathered so far
    function automatic t_out_item close_frame_check();
        t_out_item   r;
        logic [31:0] stated;
        r = '0;
        stated = {tail_bytes[7:0], tail_bytes[15:8], tail_bytes[23:16], tail_bytes[31:24]};
        if (fill_count >= MIN_FRAME_LEN && soi_bytes == SOI_MARKER
                && tail_bytes[55:40] == EOI_MARKER && stated == 32'(fill_count) - 32'd5) begin
            fill_state     = FILL_DONE;
            cap_armed      = 1'b0;
            pkt_open       = 1'b0;
            r.event_res    = EV_READY;
            r.frame_length = fill_count;
        end
        return r;
    endfunction

    function automatic t_out_item step_reassembly(input t_in_item it, output bit took_effect);
        t_out_item   r;
        logic [16:0] room;
        r = '0;
        took_effect = 1'b0;
        case (it.opcode)
            OP_ARM: begin
                if (!cap_armed && it.capacity != '0) begin
                    cap_armed   = 1'b1;
                    cap_usable  = (it.capacity > 17'(STORE_DEPTH)) ? 17'(STORE_DEPTH)
                                                                   : it.capacity;
                    took_effect = 1'b1;
                end
            end
            OP_HEADER: begin
                if (cap_armed) begin
                    took_effect   = 1'b1;
                    pkt_open      = 1'b0;
                    pkt_remaining = '0;
                    if ({8'h00, it.frame_tag} != cur_tag && it.packet_seq == 8'd1) begin
                        cur_tag    = {8'h00, it.frame_tag};
                        fill_count = '0;
                        pkts_done  = '0;
                        fill_state = FILL_COPY;
                        soi_bytes  = '0;
                        tail_bytes = '0;
                    end
                    if ({8'h00, it.frame_tag} == cur_tag
                            && int'(pkts_done) + 1 == int'(it.packet_seq)
                            && fill_state == FILL_COPY) begin
                        room = (cap_usable > fill_count) ? cap_usable - fill_count : '0;
                        if ({1'b0, it.payload_length} <= room) begin
                            pkts_done     = pkts_done + 9'd1;
                            pkt_last      = it.end_of_frame;
                            pkt_remaining = it.payload_length;
                            if (it.payload_length != '0) begin
                                pkt_open = 1'b1;
                            end else if (it.end_of_frame) begin
                                r = close_frame_check();
                            end
                        end else begin
                            fill_state  = FILL_FULL;
                            r.event_res = EV_OVERFLOW;
                        end
                    end
                end
            end
            OP_PAYLOAD: begin
                if (cap_armed && pkt_open && fill_state == FILL_COPY) begin
                    took_effect = 1'b1;
                    if (fill_count < 17'(STORE_DEPTH)) begin
                        store_img[fill_count[15:0]] = it.payload_byte;
                        if (int'(fill_count) >= written_top)
                            written_top = int'(fill_count) + 1;
                    end
                    if (fill_count == 17'd0)
                        soi_bytes = {it.payload_byte, 8'h00};
                    else if (fill_count == 17'd1)
                        soi_bytes = {soi_bytes[15:8], it.payload_byte};
                    tail_bytes    = {tail_bytes[47:0], it.payload_byte};
                    fill_count    = fill_count + 17'd1;
                    pkt_remaining = pkt_remaining - 16'd1;
                    if (pkt_remaining == '0) begin
                        pkt_open = 1'b0;
                        if (pkt_last)
                            r = close_frame_check();
                    end
                end
            end
            default: begin
                took_effect = 1'b1;
                r.event_res = EV_READ;
                r.read_data = store_img[it.read_address];
            end
        endcase
        return r;
    endfunction

    // unused fields carry random values so every bit of the item toggles
    function automatic t_in_item random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    // read-back address inside the part of the store already written
    function automatic logic [15:0] pick_read_addr();
        if (written_top == 0)
            return '0;
        return 16'($urandom_range(0, written_top - 1));
    endfunction

    function automatic t_in_item arm_item(input logic [16:0] cap);
        t_in_item it;
        it = random_item();
        it.opcode   = OP_ARM;
        it.capacity = cap;
        return it;
    endfunction

    function automatic t_in_item header_item(input logic [7:0] tag, input logic [7:0] seq,
                                             input logic eof, input logic [15:0] len);
        t_in_item it;
        it = random_item();
        it.opcode         = OP_HEADER;
        it.frame_tag      = tag;
        it.packet_seq     = seq;
        it.end_of_frame   = eof;
        it.payload_length = len;
        return it;
    endfunction

    function automatic t_in_item payload_item(input logic [7:0] data);
        t_in_item it;
        it = random_item();
        it.opcode       = OP_PAYLOAD;
        it.payload_byte = data;
        return it;
    endfunction

    function automatic t_in_item read_item(input logic [15:0] addr);
        t_in_item it;
        it = random_item();
        it.opcode       = OP_READ;
        it.read_address = addr;
        return it;
    endfunction

    function automatic void add_row(input t_in_item stim, input bit typed, input t_event ev,
                                    input logic [16:0] len, input logic [7:0] data);
        t_step_row row;
        row.stim               = stim;
        row.typed              = typed;
        row.want.event_res     = ev;
        row.want.frame_length  = len;
        row.want.read_data     = data;
        directed_steps.push_back(row);
    endfunction

    // presents one transaction in bursts with random gaps, returns once it is taken
    task automatic send_item(input t_in_item it);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic issue(input t_in_item it);
        t_out_item predicted;
        bit        effective;
        send_item(it);
        predicted = step_reassembly(it, effective);
        pending_results.push_back(predicted);
        if (effective)
            effective_items++;
    endtask

    // one capture attempt: arm, then a frame split into packets, mostly well formed
    task automatic run_episode();
        logic [7:0]  img [$];
        int          plens [$];
        int          img_len, n_pkts, left, pos, sent, plen_now, p, b;
        logic [7:0]  tag, seq;
        logic [16:0] cap;
        int unsigned pick;
        t_in_item    extra;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            cap = '0;
        else if (pick == 1)
            cap = 17'($urandom_range(65537, 131071));
        else
            cap = 17'($urandom_range(9, 300));
        issue(arm_item(cap));

        pick = $urandom_range(0, 9);
        if (pick == 0)
            img_len = $urandom_range(0, 8);
        else if (pick == 1 && cap_usable < 17'd200)
            img_len = int'(cap_usable) + $urandom_range(1, 16);
        else
            img_len = $urandom_range(9, 48);

        for (b = 0; b < img_len; b++) img.push_back(8'($urandom));
        if (img_len >= 9 && $urandom_range(0, 5) != 0) begin
            img[0]           = SOI_MARKER[15:8];
            img[1]           = SOI_MARKER[7:0];
            img[img_len - 7] = EOI_MARKER[15:8];
            img[img_len - 6] = EOI_MARKER[7:0];
            for (b = 0; b < 4; b++) img[img_len - 4 + b] = 8'((img_len - 5) >> (8 * b));
            // occasional single bit error in an otherwise good frame
            if ($urandom_range(0, 7) == 0)
                img[$urandom_range(0, img_len - 1)] ^= 8'h01 << $urandom_range(0, 7);
        end

        if ($urandom_range(0, 19) == 0) begin
            tag = cur_tag[7:0];
        end else begin
            tag = 8'($urandom);
            while ({8'h00, tag} == cur_tag) tag = 8'($urandom);
        end

        n_pkts = $urandom_range(1, 4);
        left   = img_len;
        for (p = 0; p < n_pkts; p++) begin
            plen_now = (p == n_pkts - 1) ? left : $urandom_range(0, left);
            plens.push_back(plen_now);
            left -= plen_now;
        end

        pos = 0;
        for (p = 0; p < n_pkts; p++) begin
            seq = 8'(p + 1);
            if ($urandom_range(0, 39) == 0)
                seq = seq + 8'($urandom_range(1, 3));
            issue(header_item(tag, seq, p == n_pkts - 1, 16'(plens[p])));
            sent = plens[p];
            // cut a packet short now and then, the next header abandons it
            if ($urandom_range(0, 29) == 0)
                sent = $urandom_range(0, sent);
            for (b = 0; b < sent; b++) begin
                if ($urandom_range(0, 15) == 0)
                    issue(read_item(pick_read_addr()));
                issue(payload_item(img[pos + b]));
            end
            pos += plens[p];
        end
        if ($urandom_range(0, 2) == 0) begin
            extra = random_item();
            if (extra.opcode == OP_READ)
                extra.read_address = pick_read_addr();
            issue(extra);
        end
    endtask

    // receiver: short stalls between free runs of random length, some of them long
    initial begin
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge clk);
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (free_left != 0) begin
                free_left--;
                out_stall <= 1'b0;
            end else begin
                free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(0, 8);
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
        end
    end

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_ERRORS)
                $display("unexpected result transaction: ev %0d len %0d data 0x%02h",
                         got.event_res, got.frame_length, got.read_data);
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.event_res == EV_READY)
                frames_ready++;
            else if (want.event_res == EV_OVERFLOW)
                overflows_seen++;
            else if (want.event_res == EV_READ)
                reads_seen++;
            if (got.event_res !== want.event_res || got.frame_length !== want.frame_length
                    || got.read_data !== want.read_data) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("result %0d mismatch: expected ev %0d len %0d data 0x%02h, %s",
                             results_checked, want.event_res, want.frame_length,
                             want.read_data,
                             $sformatf("got ev %0d len %0d data 0x%02h", got.event_res,
                                       got.frame_length, got.read_data));
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            check_result(out_data);
    end

    initial begin
        t_out_item  predicted;
        bit         effective;
        int         random_start;

        // unarmed, arm corner cases, then a short failing frame that keeps copying
        add_row(payload_item(8'h00), 1'b1, EV_NONE, '0, '0);
        add_row(header_item(8'h01, 8'd1, 1'b1, 16'd0), 1'b1, EV_NONE, '0, '0);
        add_row(arm_item(17'd0), 1'b1, EV_NONE, '0, '0);
        add_row(arm_item(17'h1FFFF), 1'b1, EV_NONE, '0, '0);
        add_row(arm_item(17'd1), 1'b1, EV_NONE, '0, '0);
        add_row(payload_item(8'h11), 1'b1, EV_NONE, '0, '0);
        add_row(header_item(8'h00, 8'd1, 1'b1, 16'd0), 1'b0, EV_NONE, '0, '0);
        add_row(header_item(8'h00, 8'd2, 1'b0, 16'd3), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hAB), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hCD), 1'b0, EV_NONE, '0, '0);
        // abandons the open packet and does not fit the space left
        add_row(header_item(8'h00, 8'd3, 1'b0, 16'hFFFF), 1'b1, EV_OVERFLOW, '0, '0);
        add_row(payload_item(8'h77), 1'b1, EV_NONE, '0, '0);
        // smallest good frame, nine bytes over two packets
        add_row(header_item(8'hFF, 8'd1, 1'b0, 16'd3), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hFF), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hD8), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hFF), 1'b0, EV_NONE, '0, '0);
        add_row(header_item(8'hFF, 8'd2, 1'b1, 16'd6), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hD9), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'hA5), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'h04), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'h00), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'h00), 1'b0, EV_NONE, '0, '0);
        add_row(payload_item(8'h00), 1'b1, EV_READY, 17'd9, '0);
        add_row(read_item(16'd0), 1'b1, EV_READ, '0, 8'hFF);
        add_row(read_item(16'd4), 1'b1, EV_READ, '0, 8'hA5);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            send_item(directed_steps[i].stim);
            predicted = step_reassembly(directed_steps[i].stim, effective);
            if (effective)
                effective_items++;
            pending_results.push_back(directed_steps[i].typed ? directed_steps[i].want
                                                              : predicted);
        end

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
            run_episode();

        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_SETTLE) @(posedge clk);

        $display("%0d transactions sent (%0d acted on), %0d results checked, %0d mismatches",
                 items_sent, effective_items, results_checked, fail_count);
        $display("%0d frames completed, %0d overflows, %0d read-backs of written bytes",
                 frames_ready, overflows_seen, reads_seen);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS video_frame_reassembler_unit");
        else
            $display("FAIL video_frame_reassembler_unit");
        $finish;
    end

endmodule
